### design/hcp_pkg.sv
// ----------------------------------------------------------------------------
// hcp_pkg
// Shared types and constants of the Harris corner pixel pipeline.
// ----------------------------------------------------------------------------
package hcp_pkg;

  localparam int MAX_WIDTH_DEF = 1024;

  localparam logic [10:0] IMAGE_WIDTH_RST      = 11'd640;
  localparam logic [15:0] IMAGE_HEIGHT_RST     = 16'd480;
  localparam logic [15:0] HARRIS_K_RST         = 16'd3932;
  localparam logic [46:0] CORNER_THRESHOLD_RST = 47'd50000;

  // configuration register indexes
  localparam logic [1:0] CFG_IMAGE_WIDTH      = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT     = 2'd1;
  localparam logic [1:0] CFG_HARRIS_K         = 2'd2;
  localparam logic [1:0] CFG_CORNER_THRESHOLD = 2'd3;

  // window modes of the datapath
  localparam logic [1:0] MODE_BLUR = 2'd0;
  localparam logic [1:0] MODE_GRAD = 2'd1;
  localparam logic [1:0] MODE_RESP = 2'd2;
  localparam logic [1:0] MODE_EMIT = 2'd3;

  // reciprocals with 16 fraction bits, exact for sums up to 9*255
  localparam logic [13:0] RECIP_6 = 14'd10923;
  localparam logic [13:0] RECIP_9 = 14'd7282;

  typedef struct packed {
    logic       kind;
    logic [7:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  pixel_out;
    logic        is_corner;
    logic [46:0] response;
    logic        last_of_frame;
  } out_item_t;

  typedef struct packed {
    logic              take_pixel;
    logic              tap_go;
    logic              tap_first;
    logic signed [2:0] tap_dy;
    logic signed [2:0] tap_dx;
    logic [1:0]        mode;
    logic              blur_store;
    logic              grad_store;
    logic              resp_mul;
    logic              resp_det;
    logic              resp_pen;
    logic              resp_store;
    logic              frame_end;
    logic              emit_fin;
  } cmd_t;

  typedef struct packed {
    logic can_blur;
    logic can_grad;
    logic can_resp;
    logic need_emit;
    logic flush_ok;
    logic out_free;
  } status_t;

endpackage

### design/hcp_ctrl.sv
// ----------------------------------------------------------------------------
// hcp_ctrl
// Sequencer: accepts items, walks the window taps of each stage and issues
// the store, response and emit steps to the datapath.
// ----------------------------------------------------------------------------
module hcp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_kind_i,
  output logic             in_stall_o,
  input  hcp_pkg::status_t st_i,
  output hcp_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ADV   = 4'd1;
  localparam logic [3:0] S_WIN   = 4'd2;
  localparam logic [3:0] S_DRAIN = 4'd3;
  localparam logic [3:0] S_BFIN  = 4'd4;
  localparam logic [3:0] S_GFIN  = 4'd5;
  localparam logic [3:0] S_R1    = 4'd6;
  localparam logic [3:0] S_R2    = 4'd7;
  localparam logic [3:0] S_R3    = 4'd8;
  localparam logic [3:0] S_R4    = 4'd9;
  localparam logic [3:0] S_FRAME = 4'd10;
  localparam logic [3:0] S_EFIN  = 4'd11;

  logic [3:0]        state_q, state_d;
  logic [1:0]        mode_q, mode_d;
  logic signed [2:0] tr_q, tr_d, tc_q, tc_d;
  logic signed [2:0] rad;

  assign rad = (mode_q == hcp_pkg::MODE_EMIT) ? 3'sd2 : 3'sd1;

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    tr_d    = tr_q;
    tc_d    = tc_q;
    cmd_o   = '0;
    cmd_o.mode   = mode_q;
    cmd_o.tap_dy = tr_q;
    cmd_o.tap_dx = tc_q;
    in_stall_o   = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!in_kind_i) begin
            cmd_o.take_pixel = 1'b1;
            state_d = S_ADV;
          end else if (st_i.flush_ok) begin
            mode_d  = hcp_pkg::MODE_EMIT;
            tr_d    = -3'sd2;
            tc_d    = -3'sd2;
            state_d = S_WIN;
          end
        end
      end
      S_ADV: begin
        tr_d    = -3'sd1;
        tc_d    = -3'sd1;
        state_d = S_WIN;
        if (st_i.can_blur) begin
          mode_d = hcp_pkg::MODE_BLUR;
        end else if (st_i.can_grad) begin
          mode_d = hcp_pkg::MODE_GRAD;
        end else if (st_i.can_resp) begin
          mode_d = hcp_pkg::MODE_RESP;
        end else begin
          state_d = S_FRAME;
        end
      end
      S_WIN: begin
        cmd_o.tap_go    = 1'b1;
        cmd_o.tap_first = (tr_q == -rad) && (tc_q == -rad);
        if (tc_q == rad) begin
          tc_d = -rad;
          tr_d = tr_q + 3'sd1;
          if (tr_q == rad) begin
            state_d = S_DRAIN;
          end
        end else begin
          tc_d = tc_q + 3'sd1;
        end
      end
      S_DRAIN: begin
        case (mode_q)
          hcp_pkg::MODE_BLUR: state_d = S_BFIN;
          hcp_pkg::MODE_GRAD: state_d = S_GFIN;
          hcp_pkg::MODE_RESP: state_d = S_R1;
          default:            state_d = S_EFIN;
        endcase
      end
      S_BFIN: begin
        cmd_o.blur_store = 1'b1;
        state_d = S_ADV;
      end
      S_GFIN: begin
        cmd_o.grad_store = 1'b1;
        state_d = S_ADV;
      end
      S_R1: begin
        cmd_o.resp_mul = 1'b1;
        state_d = S_R2;
      end
      S_R2: begin
        cmd_o.resp_det = 1'b1;
        state_d = S_R3;
      end
      S_R3: begin
        cmd_o.resp_pen = 1'b1;
        state_d = S_R4;
      end
      S_R4: begin
        cmd_o.resp_store = 1'b1;
        state_d = S_ADV;
      end
      S_FRAME: begin
        cmd_o.frame_end = 1'b1;
        if (st_i.need_emit) begin
          mode_d  = hcp_pkg::MODE_EMIT;
          tr_d    = -3'sd2;
          tc_d    = -3'sd2;
          state_d = S_WIN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EFIN: begin
        if (st_i.out_free) begin
          cmd_o.emit_fin = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= hcp_pkg::MODE_BLUR;
      tr_q    <= '0;
      tc_q    <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      tr_q    <= tr_d;
      tc_q    <= tc_d;
    end
  end

endmodule

### design/hcp_datapath.sv
// ----------------------------------------------------------------------------
// hcp_datapath
// Line rings, position counters, window accumulators, Harris arithmetic,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module hcp_datapath #(
  parameter int MAX_WIDTH = hcp_pkg::MAX_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hcp_pkg::cmd_t      cmd_i,
  output hcp_pkg::status_t   st_o,
  input  logic [7:0]         in_pixel_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [46:0]        cfg_data_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output hcp_pkg::out_item_t out_data_o
);

  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int CMPW    = (WW > 11) ? WW : 11;
  localparam int RING_AW = $clog2(8 * MAX_WIDTH);
  localparam int RING_D  = 1 << RING_AW;
  localparam int PW      = $clog2(5 * MAX_WIDTH + 7);

  // configuration
  logic [10:0] width_q;
  logic [15:0] height_q;
  logic [15:0] k_q;
  logic [46:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= hcp_pkg::IMAGE_WIDTH_RST;
      height_q <= hcp_pkg::IMAGE_HEIGHT_RST;
      k_q      <= hcp_pkg::HARRIS_K_RST;
      thr_q    <= hcp_pkg::CORNER_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        hcp_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[10:0];
        hcp_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[15:0];
        hcp_pkg::CFG_HARRIS_K:     k_q      <= cfg_data_i[15:0];
        default:                   thr_q    <= cfg_data_i;
      endcase
    end
  end

  logic [CMPW-1:0] w_ext, w_clip;
  logic [WW-1:0]   w;
  logic [15:0]     h;

  assign w_ext  = CMPW'(width_q);
  assign w_clip = (w_ext < CMPW'(8)) ? CMPW'(8) :
                  (w_ext > CMPW'(MAX_WIDTH)) ? CMPW'(MAX_WIDTH) : w_ext;
  assign w      = WW'(w_clip);
  assign h      = (height_q < 16'd8) ? 16'd8 : height_q;

  // position counters
  logic [15:0]        in_row_q, av_row_q, b_row_q, g_row_q, r_row_q, o_row_q;
  logic [WW-1:0]      in_col_q, av_col_q, b_col_q, g_col_q, r_col_q, o_col_q;
  logic [RING_AW-1:0] in_ptr_q, b_ptr_q, g_ptr_q, r_ptr_q, o_ptr_q;
  logic [PW-1:0]      pend_q;
  logic               wrap_q;

  function automatic logic [15:0] dep_row(input logic [15:0] r, input logic [15:0] hh);
    logic [15:0] nr;
    nr = r + 16'd1;
    return (nr < hh) ? nr : hh - 16'd1;
  endfunction

  function automatic logic [WW-1:0] dep_col(input logic [WW-1:0] c, input logic [WW-1:0] ww);
    logic [WW-1:0] nc;
    nc = c + WW'(1);
    return (nc < ww) ? nc : ww - WW'(1);
  endfunction

  logic [15:0]   bdr, gdr, rdr;
  logic [WW-1:0] bdc, gdc, rdc;

  assign bdr = dep_row(b_row_q, h);
  assign bdc = dep_col(b_col_q, w);
  assign gdr = dep_row(g_row_q, h);
  assign gdc = dep_col(g_col_q, w);
  assign rdr = dep_row(r_row_q, h);
  assign rdc = dep_col(r_col_q, w);

  logic            out_valid_q;
  logic [PW-1:0]   emit_lim;

  assign emit_lim = (PW'(w) << 2) + PW'(w) + PW'(5);

  assign st_o.can_blur  = (b_row_q < h) &&
                          ((bdr < av_row_q) || ((bdr == av_row_q) && (bdc <= av_col_q)));
  assign st_o.can_grad  = (g_row_q < h) &&
                          ((gdr < b_row_q) || ((gdr == b_row_q) && (gdc < b_col_q)));
  assign st_o.can_resp  = (r_row_q < h) &&
                          ((rdr < g_row_q) || ((rdr == g_row_q) && (rdc < g_col_q)));
  assign st_o.need_emit = pend_q > emit_lim;
  assign st_o.flush_ok  = (in_row_q == 16'd0) && (in_col_q == '0) && (pend_q != '0);
  assign st_o.out_free  = !out_valid_q || !out_stall_i;

  // window tap address and bounds
  logic [15:0]        cy;
  logic [WW-1:0]      cx;
  logic [RING_AW-1:0] cptr, roff, row_addr, rd_addr;
  logic [1:0]         ady, adx;
  logic               row_ok, col_ok, interior, tap_ok;

  always_comb begin
    case (cmd_i.mode)
      hcp_pkg::MODE_BLUR: begin cy = b_row_q; cx = b_col_q; cptr = b_ptr_q; end
      hcp_pkg::MODE_GRAD: begin cy = g_row_q; cx = g_col_q; cptr = g_ptr_q; end
      hcp_pkg::MODE_RESP: begin cy = r_row_q; cx = r_col_q; cptr = r_ptr_q; end
      default:            begin cy = o_row_q; cx = o_col_q; cptr = o_ptr_q; end
    endcase
  end

  always_comb begin
    ady = cmd_i.tap_dy[2] ? 2'(-cmd_i.tap_dy) : cmd_i.tap_dy[1:0];
    adx = cmd_i.tap_dx[2] ? 2'(-cmd_i.tap_dx) : cmd_i.tap_dx[1:0];
    if (cmd_i.tap_dy[2]) begin
      row_ok = cy >= 16'(ady);
    end else begin
      row_ok = (17'(cy) + 17'(ady)) < 17'(h);
    end
    if (cmd_i.tap_dx[2]) begin
      col_ok = cx >= WW'(adx);
    end else begin
      col_ok = ((WW+1)'(cx) + (WW+1)'(adx)) < (WW+1)'(w);
    end
    interior = (cy != 16'd0) && (cy != h - 16'd1) && (cx != '0) && (cx != w - WW'(1));
    tap_ok   = (cmd_i.mode == hcp_pkg::MODE_GRAD) ? interior : (row_ok && col_ok);
    case (ady)
      2'd2:    roff = RING_AW'(w) << 1;
      2'd1:    roff = RING_AW'(w);
      default: roff = '0;
    endcase
    row_addr = cmd_i.tap_dy[2] ? (cptr - roff) : (cptr + roff);
    rd_addr  = row_addr + {{(RING_AW-3){cmd_i.tap_dx[2]}}, cmd_i.tap_dx};
  end

  // results written back to the rings
  logic [7:0]         blur_val;
  logic signed [11:0] gx_acc_q, gy_acc_q;
  logic [50:0]        resp_full;
  logic [46:0]        resp_val;

  // line rings
  logic [7:0]  raw_mem  [RING_D];
  logic [7:0]  blur_mem [RING_D];
  logic [21:0] grad_mem [RING_D];
  logic [46:0] resp_mem [RING_D];
  logic [7:0]  orig_mem [RING_D];
  logic [7:0]  raw_rd_q, blur_rd_q, orig_rd_q;
  logic [21:0] grad_rd_q;
  logic [46:0] resp_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_pixel) raw_mem[in_ptr_q] <= in_pixel_i;
    raw_rd_q <= raw_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_pixel) orig_mem[in_ptr_q] <= in_pixel_i;
    orig_rd_q <= orig_mem[o_ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.blur_store) blur_mem[b_ptr_q] <= blur_val;
    blur_rd_q <= blur_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.grad_store) grad_mem[g_ptr_q] <= {gx_acc_q[10:0], gy_acc_q[10:0]};
    grad_rd_q <= grad_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp_store) resp_mem[r_ptr_q] <= resp_val;
    resp_rd_q <= resp_mem[rd_addr];
  end

  // tap data arrives in the cycle after the read is issued
  logic              tap_vld_q;
  logic signed [2:0] tap_dy_q, tap_dx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_vld_q <= 1'b0;
    end else begin
      tap_vld_q <= cmd_i.tap_go && tap_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    tap_dy_q <= cmd_i.tap_dy;
    tap_dx_q <= cmd_i.tap_dx;
  end

  // accumulators
  logic [11:0]        bsum_q;
  logic [3:0]         bcnt_q;
  logic signed [25:0] sxx_q, sxy_q, syy_q, tra_q;
  logic [46:0]        max_q, ctr_q;
  logic signed [11:0] bterm, bterm2, tx, ty;
  logic signed [10:0] gxr, gyr;
  logic signed [21:0] pxx, pxy, pyy;

  assign bterm  = signed'({4'b0, blur_rd_q});
  assign bterm2 = bterm <<< 1;
  assign tx     = (tap_dy_q == 3'sd0) ? bterm2 : bterm;
  assign ty     = (tap_dx_q == 3'sd0) ? bterm2 : bterm;
  assign gxr    = signed'(grad_rd_q[21:11]);
  assign gyr    = signed'(grad_rd_q[10:0]);
  assign pxx    = gxr * gxr;
  assign pxy    = gxr * gyr;
  assign pyy    = gyr * gyr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.tap_go && cmd_i.tap_first) begin
      bsum_q   <= '0;
      bcnt_q   <= '0;
      gx_acc_q <= '0;
      gy_acc_q <= '0;
      sxx_q    <= '0;
      sxy_q    <= '0;
      syy_q    <= '0;
      tra_q    <= '0;
      max_q    <= '0;
      ctr_q    <= '0;
    end else if (tap_vld_q) begin
      case (cmd_i.mode)
        hcp_pkg::MODE_BLUR: begin
          bsum_q <= bsum_q + 12'(raw_rd_q);
          bcnt_q <= bcnt_q + 4'd1;
        end
        hcp_pkg::MODE_GRAD: begin
          if (tap_dx_q > 3'sd0) gx_acc_q <= gx_acc_q + tx;
          if (tap_dx_q < 3'sd0) gx_acc_q <= gx_acc_q - tx;
          if (tap_dy_q > 3'sd0) gy_acc_q <= gy_acc_q + ty;
          if (tap_dy_q < 3'sd0) gy_acc_q <= gy_acc_q - ty;
        end
        hcp_pkg::MODE_RESP: begin
          sxx_q <= sxx_q + 26'(pxx);
          sxy_q <= sxy_q + 26'(pxy);
          syy_q <= syy_q + 26'(pyy);
          tra_q <= tra_q + 26'(pxx) + 26'(pyy);
        end
        default: begin
          if (resp_rd_q > max_q) max_q <= resp_rd_q;
          if ((tap_dy_q == 3'sd0) && (tap_dx_q == 3'sd0)) ctr_q <= resp_rd_q;
        end
      endcase
    end
  end

  // clipped mean: divide by 4, 6 or 9
  logic [25:0] bprod;

  assign bprod    = 26'(bsum_q) * 26'((bcnt_q == 4'd6) ? hcp_pkg::RECIP_6 : hcp_pkg::RECIP_9);
  assign blur_val = (bcnt_q == 4'd4) ? bsum_q[9:2] : bprod[23:16];

  // Harris response: det - floor(k * trace^2 / 2^16), clamped at zero
  logic signed [51:0] pa_q, pb_q;
  logic [49:0]        t2_q, ph_q;
  logic signed [48:0] det_q;
  logic [31:0]        pl_q;
  logic [50:0]        pen_q;
  logic [24:0]        trace;

  assign trace = tra_q[24:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp_mul) begin
      pa_q <= 52'(sxx_q) * 52'(syy_q);
      pb_q <= 52'(sxy_q) * 52'(sxy_q);
      t2_q <= 50'(trace) * 50'(trace);
    end
    if (cmd_i.resp_det) begin
      det_q <= 49'(pa_q - pb_q);
      ph_q  <= 50'(t2_q[49:16]) * 50'(k_q);
      pl_q  <= 32'(t2_q[15:0]) * 32'(k_q);
    end
    if (cmd_i.resp_pen) begin
      pen_q <= 51'(ph_q) + 51'(pl_q[31:16]);
    end
  end

  assign resp_full = (!det_q[48] && ({2'b00, det_q} > pen_q)) ?
                     ({2'b00, det_q} - pen_q) : 51'd0;
  assign resp_val  = resp_full[46:0];

  // suppression and output item
  logic [46:0] kept;
  logic        corner;

  assign kept   = (max_q == ctr_q) ? ctr_q : 47'd0;
  assign corner = kept > thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_fin) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_fin) begin
      out_data_o.pixel_out     <= corner ? 8'd0 : orig_rd_q;
      out_data_o.is_corner     <= corner;
      out_data_o.response      <= kept;
      out_data_o.last_of_frame <= (o_row_q == h - 16'd1) && (o_col_q == w - WW'(1));
    end
  end

  assign out_valid_o = out_valid_q;

  // counter updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q <= '0; in_col_q <= '0; in_ptr_q <= '0;
      av_row_q <= '0; av_col_q <= '0; wrap_q <= 1'b0; pend_q <= '0;
      b_row_q  <= '0; b_col_q  <= '0; b_ptr_q  <= '0;
      g_row_q  <= '0; g_col_q  <= '0; g_ptr_q  <= '0;
      r_row_q  <= '0; r_col_q  <= '0; r_ptr_q  <= '0;
      o_row_q  <= '0; o_col_q  <= '0; o_ptr_q  <= '0;
    end else if (cfg_we_i) begin
      // any register write restarts the stream
      in_row_q <= '0; in_col_q <= '0; in_ptr_q <= '0;
      av_row_q <= '0; av_col_q <= '0; wrap_q <= 1'b0; pend_q <= '0;
      b_row_q  <= '0; b_col_q  <= '0; b_ptr_q  <= '0;
      g_row_q  <= '0; g_col_q  <= '0; g_ptr_q  <= '0;
      r_row_q  <= '0; r_col_q  <= '0; r_ptr_q  <= '0;
      o_row_q  <= '0; o_col_q  <= '0; o_ptr_q  <= '0;
    end else begin
      if (cmd_i.take_pixel) begin
        in_ptr_q <= in_ptr_q + RING_AW'(1);
        pend_q   <= pend_q + PW'(1);
        av_row_q <= in_row_q;
        av_col_q <= in_col_q;
        if (in_col_q + WW'(1) >= w) begin
          in_col_q <= '0;
          if (in_row_q + 16'd1 >= h) begin
            in_row_q <= '0;
            wrap_q   <= 1'b1;
          end else begin
            in_row_q <= in_row_q + 16'd1;
          end
        end else begin
          in_col_q <= in_col_q + WW'(1);
        end
      end
      if (cmd_i.blur_store) begin
        b_ptr_q <= b_ptr_q + RING_AW'(1);
        if (b_col_q + WW'(1) >= w) begin
          b_col_q <= '0;
          b_row_q <= b_row_q + 16'd1;
        end else begin
          b_col_q <= b_col_q + WW'(1);
        end
      end
      if (cmd_i.grad_store) begin
        g_ptr_q <= g_ptr_q + RING_AW'(1);
        if (g_col_q + WW'(1) >= w) begin
          g_col_q <= '0;
          g_row_q <= g_row_q + 16'd1;
        end else begin
          g_col_q <= g_col_q + WW'(1);
        end
      end
      if (cmd_i.resp_store) begin
        r_ptr_q <= r_ptr_q + RING_AW'(1);
        if (r_col_q + WW'(1) >= w) begin
          r_col_q <= '0;
          r_row_q <= r_row_q + 16'd1;
        end else begin
          r_col_q <= r_col_q + WW'(1);
        end
      end
      if (cmd_i.frame_end && wrap_q) begin
        // stages restart on the new frame's first pixel
        wrap_q  <= 1'b0;
        b_row_q <= '0; b_col_q <= '0; b_ptr_q <= in_ptr_q;
        g_row_q <= '0; g_col_q <= '0; g_ptr_q <= in_ptr_q;
        r_row_q <= '0; r_col_q <= '0; r_ptr_q <= in_ptr_q;
      end
      if (cmd_i.emit_fin) begin
        pend_q  <= pend_q - PW'(1);
        o_ptr_q <= o_ptr_q + RING_AW'(1);
        if (o_col_q + WW'(1) >= w) begin
          o_col_q <= '0;
          o_row_q <= (o_row_q + 16'd1 >= h) ? 16'd0 : o_row_q + 16'd1;
        end else begin
          o_col_q <= o_col_q + WW'(1);
        end
      end
    end
  end

endmodule

### design/harris_corner_pixel_pipeline.sv
// ----------------------------------------------------------------------------
// harris_corner_pixel_pipeline
// Harris corner marking on a raster pixel stream with line-ring stages.
// ----------------------------------------------------------------------------
// One item is handled at a time. A pixel item runs the blur, gradient and
// response stages that it unlocks, each one window read per cycle from a
// single-port line ring: a 3x3 window for each stage, and a 5x5
// suppression window for an emitted result. The last pixel of a frame
// finishes the bottom rows of all three stages. A flush item at a frame
// boundary drains one delayed result; the block takes the next item
// while a result waits in the output register. Results leave 5*W+5 pixel
// items after their own pixel. The line rings need no clearing after reset.
module harris_corner_pixel_pipeline #(
  parameter int MAX_WIDTH = hcp_pkg::MAX_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  hcp_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hcp_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [46:0]        cfg_data_i
);

  hcp_pkg::cmd_t    cmd;
  hcp_pkg::status_t st;

  hcp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_data_i.kind),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  hcp_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .in_pixel_i  (in_data_i.pixel_in),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // a pixel transfer always starts stage work
  a_pixel_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !in_data_i.kind) |=> in_stall_o)
    else $error("pixel transfer did not start stage work");

  // a flush with nothing to drain is dropped at once
  a_flush_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.kind && !st.flush_ok) |=> !in_stall_o)
    else $error("idle flush held the input");

  // a result is only loaded into a free output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_fin |-> st.out_free)
    else $error("result overwrote a waiting result");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_fin |=> out_valid_o)
    else $error("finished result not presented");

endmodule

### bench/harris_corner_pixel_pipeline_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// harris_corner_pixel_pipeline_tb
// Streams frames and short bursts of grey pixels through the corner pipeline. A
// bit-accurate predictor of the line stages, the tensor response and the
// suppression window builds the expected results. A checker compares every
// transfer on the result channel, field by field, against the oldest entry.
// ----------------------------------------------------------------------------
module harris_corner_pixel_pipeline_tb;

  localparam int RING       = 8192;
  localparam int HOLD_LEN   = 12000;
  localparam int QUIET_MAX  = 200000;
  localparam int ITEM_GOAL  = 1850;
  localparam logic [46:0] THR_MAX = 47'h7FFF_FFFF_FFFF;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  hcp_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  hcp_pkg::out_item_t out_data;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [46:0]        cfg_data = '0;

  harris_corner_pixel_pipeline u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [10:0] cfg_w = hcp_pkg::IMAGE_WIDTH_RST;
  logic [15:0] cfg_h = hcp_pkg::IMAGE_HEIGHT_RST;
  logic [15:0] cfg_k = hcp_pkg::HARRIS_K_RST;
  logic [46:0] cfg_thr = hcp_pkg::CORNER_THRESHOLD_RST;
  byte unsigned    raw_ring [RING];
  byte unsigned    blur_ring[RING];
  byte unsigned    orig_ring[RING];
  shortint         gx_ring  [RING];
  shortint         gy_ring  [RING];
  longint unsigned resp_ring[RING];
  int unsigned     in_col, in_row, out_col, out_row, blur_n, grad_n, resp_n;
  longint unsigned in_seq, out_seq, frame_base;

  hcp_pkg::out_item_t expected_q[$];
  int  errors = 0, n_items = 0, n_results = 0, n_frames = 0;
  int  quiet_n = 0;
  int  hold_req = 0, hold_seen = 0, hold_left = 0;
  bit  no_idle = 1'b0;

  function automatic int unsigned eff_w();
    int unsigned w = cfg_w;
    if (w < 8) w = 8;
    if (w > 1024) w = 1024;
    return w;
  endfunction

  function automatic int unsigned eff_h();
    return (cfg_h < 8) ? 8 : cfg_h;
  endfunction

  function automatic int unsigned slot_of(longint unsigned s);
    return int'(s % RING);
  endfunction

  function automatic int unsigned lo_lim(int unsigned v, int unsigned r);
    return (v >= r) ? v - r : 0;
  endfunction

  function automatic int unsigned hi_lim(int unsigned v, int unsigned r, int unsigned n);
    return (v + r < n) ? v + r : n - 1;
  endfunction

  function automatic int unsigned needed_px(int unsigned p, int unsigned w, int unsigned h);
    return hi_lim(p / w, 1, h) * w + hi_lim(p % w, 1, w);
  endfunction

  function automatic int blur_px(int unsigned y, int unsigned x, int unsigned w);
    return blur_ring[slot_of(frame_base + y * w + x)];
  endfunction

  function automatic void do_blur(int unsigned p, int unsigned w, int unsigned h);
    int unsigned y = p / w, x = p % w, sum = 0, cnt = 0;
    for (int unsigned yy = lo_lim(y, 1); yy <= hi_lim(y, 1, h); yy++)
      for (int unsigned xx = lo_lim(x, 1); xx <= hi_lim(x, 1, w); xx++) begin
        sum += raw_ring[slot_of(frame_base + yy * w + xx)];
        cnt++;
      end
    blur_ring[slot_of(frame_base + p)] = byte'(sum / cnt);
  endfunction

  function automatic void do_grad(int unsigned p, int unsigned w, int unsigned h);
    int unsigned y = p / w, x = p % w;
    int gx = 0, gy = 0;
    if (y != 0 && y != h - 1 && x != 0 && x != w - 1) begin
      gx = -blur_px(y-1, x-1, w) + blur_px(y-1, x+1, w)
           - 2*blur_px(y, x-1, w) + 2*blur_px(y, x+1, w)
           - blur_px(y+1, x-1, w) + blur_px(y+1, x+1, w);
      gy = -blur_px(y-1, x-1, w) - 2*blur_px(y-1, x, w) - blur_px(y-1, x+1, w)
           + blur_px(y+1, x-1, w) + 2*blur_px(y+1, x, w) + blur_px(y+1, x+1, w);
    end
    gx_ring[slot_of(frame_base + p)] = shortint'(gx);
    gy_ring[slot_of(frame_base + p)] = shortint'(gy);
  endfunction

  function automatic void do_resp(int unsigned p, int unsigned w, int unsigned h);
    int unsigned y = p / w, x = p % w, s;
    longint sxx = 0, sxy = 0, syy = 0, det, gx, gy;
    longint unsigned trace, t2, pen, r = 0, kk = cfg_k;
    for (int unsigned yy = lo_lim(y, 1); yy <= hi_lim(y, 1, h); yy++)
      for (int unsigned xx = lo_lim(x, 1); xx <= hi_lim(x, 1, w); xx++) begin
        s = slot_of(frame_base + yy * w + xx);
        gx = gx_ring[s];
        gy = gy_ring[s];
        sxx += gx * gx;
        sxy += gx * gy;
        syy += gy * gy;
      end
    det = sxx * syy - sxy * sxy;
    trace = sxx + syy;
    t2 = trace * trace;
    pen = (t2 >> 16) * kk + (((t2 & 64'hFFFF) * kk) >> 16);
    if (det > 0 && $unsigned(det) > pen) r = $unsigned(det) - pen;
    resp_ring[slot_of(frame_base + p)] = r & 64'h7FFF_FFFF_FFFF;
  endfunction

  function automatic hcp_pkg::out_item_t next_result();
    int unsigned w = eff_w(), h = eff_h(), y = out_row, x = out_col, p;
    longint unsigned ob, center, kept;
    bit keep = 1'b1, corner;
    hcp_pkg::out_item_t r;
    p = y * w + x;
    ob = out_seq - p;
    center = resp_ring[slot_of(ob + p)];
    for (int unsigned yy = lo_lim(y, 2); yy <= hi_lim(y, 2, h); yy++)
      for (int unsigned xx = lo_lim(x, 2); xx <= hi_lim(x, 2, w); xx++)
        if (resp_ring[slot_of(ob + yy * w + xx)] > center) keep = 1'b0;
    kept = keep ? center : 0;
    corner = kept > {17'd0, cfg_thr};
    r.pixel_out     = corner ? 8'd0 : orig_ring[slot_of(out_seq)];
    r.is_corner     = corner;
    r.response      = kept[46:0];
    r.last_of_frame = (y >= h - 1) && (x >= w - 1);
    out_seq++;
    if (++out_col >= w) begin
      out_col = 0;
      if (++out_row >= h) out_row = 0;
    end
    return r;
  endfunction

  function automatic bit predict_result(hcp_pkg::in_item_t it, output hcp_pkg::out_item_t r);
    int unsigned w = eff_w(), h = eff_h(), avail, n, s;
    r = '0;
    if (it.kind) begin
      if (in_row == 0 && in_col == 0 && in_seq > out_seq) begin
        r = next_result();
        return 1'b1;
      end
      return 1'b0;
    end
    s = slot_of(in_seq);
    raw_ring[s] = it.pixel_in;
    orig_ring[s] = it.pixel_in;
    in_seq++;
    avail = in_row * w + in_col + 1;
    if (++in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    n = w * h;
    while (blur_n < n && needed_px(blur_n, w, h) < avail) begin do_blur(blur_n, w, h); blur_n++; end
    while (grad_n < n && needed_px(grad_n, w, h) < blur_n) begin do_grad(grad_n, w, h); grad_n++; end
    while (resp_n < n && needed_px(resp_n, w, h) < grad_n) begin do_resp(resp_n, w, h); resp_n++; end
    if (in_row >= h) begin
      in_row = 0;
      blur_n = 0;
      grad_n = 0;
      resp_n = 0;
      frame_base = in_seq;
    end
    if (in_seq - out_seq > 5 * w + 5) begin
      r = next_result();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [46:0] val);
    case (idx)
      hcp_pkg::CFG_IMAGE_WIDTH:      cfg_w = val[10:0];
      hcp_pkg::CFG_IMAGE_HEIGHT:     cfg_h = val[15:0];
      hcp_pkg::CFG_HARRIS_K:         cfg_k = val[15:0];
      hcp_pkg::CFG_CORNER_THRESHOLD: cfg_thr = val;
      default: ;
    endcase
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    in_seq = 0; out_seq = 0; frame_base = 0;
    blur_n = 0; grad_n = 0; resp_n = 0;
  endfunction

  // receiver: random stall, or a long hold-off counted down here
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_idle && ($urandom_range(99) < 21);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    hcp_pkg::out_item_t exp_r;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        n_results++;
        if (out_data.pixel_out !== exp_r.pixel_out) begin
          $error("pixel_out expected %0d got %0d", exp_r.pixel_out, out_data.pixel_out);
          errors++;
        end
        if (out_data.is_corner !== exp_r.is_corner) begin
          $error("is_corner expected %0d got %0d", exp_r.is_corner, out_data.is_corner);
          errors++;
        end
        if (out_data.response !== exp_r.response) begin
          $error("response expected %0d got %0d", exp_r.response, out_data.response);
          errors++;
        end
        if (out_data.last_of_frame !== exp_r.last_of_frame) begin
          $error("last_of_frame expected %0d got %0d", exp_r.last_of_frame,
                 out_data.last_of_frame);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_ni)
      quiet_n = 0;
    else
      quiet_n++;
    if (quiet_n >= QUIET_MAX) begin
      $display("timeout: no transfer for %0d cycles", quiet_n);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_item(logic kind, logic [7:0] pix);
    hcp_pkg::in_item_t  it;
    hcp_pkg::out_item_t r;
    it.kind = kind;
    it.pixel_in = pix;
    while (!no_idle && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (predict_result(it, r)) begin
      expected_q.push_back(r);
      n_items++;
    end else if (!kind) begin
      n_items++;
    end
  endtask

  // stop offering, wait for every result, then let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (50 * eff_w() + 300) @(posedge clk_i);
  endtask

  task automatic set_config(logic [10:0] w, logic [15:0] h, logic [15:0] k, logic [46:0] thr);
    logic [46:0] vals[4];
    vals[0] = {36'd0, w};
    vals[1] = {31'd0, h};
    vals[2] = {31'd0, k};
    vals[3] = thr;
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= vals[i];
      @(posedge clk_i);
      apply_reg(2'(i), vals[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] pattern_px(int pat, int unsigned y, int unsigned x, int sz);
    case (pat)
      0: return 8'($urandom);
      1: return (((y / sz) + (x / sz)) % 2 == 1) ? 8'd255 : 8'd0;
      2: return ((y % 5 == 2) && (x % 5 == 2)) ? 8'd255 : 8'($urandom_range(3));
      3: return (x >= sz && y >= sz) ? 8'd250 : 8'($urandom_range(5));
      default: return 8'd128;
    endcase
  endfunction

  // one full frame; noise adds flushes inside the frame, which are dropped
  task automatic send_frame(int pat, bit flush_end, bit noise);
    int unsigned w = eff_w(), h = eff_h();
    int sz = $urandom_range(2, 4);
    for (int unsigned y = 0; y < h; y++)
      for (int unsigned x = 0; x < w; x++) begin
        if (noise && $urandom_range(99) < 3) send_item(1'b1, 8'($urandom));
        send_item(1'b0, pattern_px(pat, y, x, sz));
      end
    n_frames++;
    if (flush_end)
      while (in_seq > out_seq) send_item(1'b1, 8'($urandom));
  endtask

  task automatic test_directed();
    set_config(11'd8, 16'd8, 16'd3932, 47'd50000);
    send_item(1'b1, 8'hFF);           // flush with nothing pending
    send_item(1'b0, 8'd0);
    send_item(1'b0, 8'd255);
    send_item(1'b1, 8'd0);            // flush mid-frame
    for (int i = 0; i < 14; i++) send_item(1'b0, (i % 3 == 0) ? 8'd255 : 8'd0);
    drain_results();
    set_config(11'd8, 16'd8, 16'd3932, 47'd50000);
    send_frame(2, 1'b1, 1'b0);
    drain_results();
  endtask

  task automatic test_register_extremes();
    set_config(11'd0, 16'd0, 16'd0, 47'd0);
    send_frame(1, 1'b1, 1'b0);
    drain_results();
    set_config(11'd9, 16'd8, 16'hFFFF, THR_MAX);
    send_frame(3, 1'b1, 1'b0);
    drain_results();
    // widest frame: a short burst only, too short to produce results
    set_config(11'h7FF, 16'hFFFF, 16'd3932, 47'd50000);
    for (int i = 0; i < 20; i++) send_item(1'b0, 8'($urandom));
    drain_results();
    set_config(11'd1024, 16'd8, 16'd1000, 47'd1);
    for (int i = 0; i < 10; i++) send_item(1'b0, 8'($urandom));
    drain_results();
  endtask

  task automatic test_back_to_back_frames();
    set_config(11'd10, 16'd9, 16'd3932, 47'd20000);
    no_idle = 1'b1;
    send_frame(0, 1'b0, 1'b0);        // next frame without flush
    send_frame(2, 1'b1, 1'b0);
    no_idle = 1'b0;
    drain_results();
  endtask

  task automatic test_backpressure();
    set_config(11'd12, 16'd8, 16'd3932, 47'd50000);
    hold_req++;
    send_frame(1, 1'b1, 1'b0);
    drain_results();
  endtask

  task automatic test_random_frames();
    logic [46:0] thr;
    logic [15:0] k;
    while (n_items < ITEM_GOAL) begin
      case ($urandom_range(3))
        0: thr = 47'd0;
        1: thr = 47'($urandom_range(100000));
        2: thr = 47'd50000;
        default: thr = {15'($urandom), 32'($urandom)};
      endcase
      case ($urandom_range(3))
        0: k = 16'd0;
        1: k = 16'hFFFF;
        default: k = 16'($urandom);
      endcase
      set_config(($urandom_range(9) == 0) ? 11'($urandom_range(17, 24))
                                          : 11'($urandom_range(8, 16)),
                 16'($urandom_range(8, 10)), k, thr);
      send_frame($urandom_range(4), 1'b1, $urandom_range(3) == 0);
      if ($urandom_range(2) == 0) send_frame($urandom_range(4), 1'b1, 1'b1);
      drain_results();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_extremes();
    test_back_to_back_frames();
    test_backpressure();
    test_random_frames();
    drain_results();
    $display("run covered %0d items, %0d results, %0d frames", n_items, n_results, n_frames);
    $display("with register extremes, long output hold-off and mid-frame flushes");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
